[src/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/pbd_pkg.sv]
// Package for the power button debouncer: widths, register indexes, reset values.
package pbd_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int DELAY_WIDTH = 16;
    localparam int LOAD_WIDTH  = (COUNT_WIDTH > DELAY_WIDTH) ? COUNT_WIDTH : DELAY_WIDTH;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = DELAY_WIDTH;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE_TICKS = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ACTIVE_LEVEL   = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_IGNORE_LID     = 2'd2;

    localparam logic [DELAY_WIDTH-1:0] DEBOUNCE_RESET = 16'd30000;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef struct packed {
        logic pressed;
        logic stable;
        logic scan_disable;
        logic scan_enable;
        logic change_event;
        logic press_event;
    } result_t;

endpackage

[src/power_button_debouncer.sv]
// Power button debouncer: one tick item in, one result item out.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  tick     | tick_valid / tick_stall   | button_level, lid_open, simulate_press
//  result   | result_valid / result_stall | pressed, stable, scan_disable, scan_enable,
//           |                           | change_event, press_event
//  cfg      | cfg_we                    | cfg_index, cfg_data
//
// One tick item per clock while tick_stall is low; its result appears in the output register on the next cycle.
// The debounce state and countdown are updated in a single register pass per tick.
// tick_stall is high only while the output register holds an item and result_stall is high.
// Reset loads the configuration defaults; the first tick after reset loads the debounced state.
module power_button_debouncer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pbd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [pbd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                                tick_valid,
    output logic                                tick_stall,
    input  logic                                button_level,
    input  logic                                lid_open,
    input  logic                                simulate_press,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                pressed,
    output logic                                stable,
    output logic                                scan_disable,
    output logic                                scan_enable,
    output logic                                change_event,
    output logic                                press_event
);

    logic [pbd_pkg::DELAY_WIDTH-1:0] ticks_reg;
    logic                            active_level_reg;
    logic                            ignore_lid_reg;

    logic            debounced_reg, debounced_next;
    logic            stable_reg, stable_next;
    pbd_pkg::count_t count_reg, count_next;
    logic            pending_reg, pending_next;
    logic            prev_level_reg;
    logic            prev_sim_reg;
    logic            init_done_reg;

    logic             result_valid_reg;
    pbd_pkg::result_t result_reg, result_next;

    logic                            accept;
    logic                            raw;
    logic                            pin_edge;
    logic                            sim_change;
    logic                            due;
    logic [pbd_pkg::LOAD_WIDTH-1:0]  load_wide;
    logic [pbd_pkg::LOAD_WIDTH-1:0]  count_max_wide;
    pbd_pkg::count_t                 count_load;

    assign tick_stall = result_valid_reg && result_stall;
    assign accept     = tick_valid && !tick_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg        <= pbd_pkg::DEBOUNCE_RESET;
            active_level_reg <= 1'b0;
            ignore_lid_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pbd_pkg::REG_DEBOUNCE_TICKS: ticks_reg        <= cfg_data;
                pbd_pkg::REG_ACTIVE_LEVEL:   active_level_reg <= cfg_data[0];
                pbd_pkg::REG_IGNORE_LID:     ignore_lid_reg   <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    assign raw = simulate_press
                 || ((ignore_lid_reg || lid_open) && (button_level == active_level_reg));
    assign pin_edge   = button_level != prev_level_reg;
    assign sim_change = simulate_press != prev_sim_reg;

    // Treat a zero delay as one tick, saturate a delay the counter cannot hold
    assign count_max_wide = pbd_pkg::LOAD_WIDTH'({pbd_pkg::COUNT_WIDTH{1'b1}});
    always_comb
    begin
        load_wide = pbd_pkg::LOAD_WIDTH'(ticks_reg);
        if (ticks_reg == '0)
            load_wide = pbd_pkg::LOAD_WIDTH'(1);
        if (load_wide > count_max_wide)
            load_wide = count_max_wide;
    end
    assign count_load = load_wide[pbd_pkg::COUNT_WIDTH-1:0];

    always_comb
    begin
        debounced_next = debounced_reg;
        stable_next    = stable_reg;
        count_next     = count_reg;
        pending_next   = pending_reg;
        due            = 1'b0;
        result_next    = '0;

        if (!init_done_reg)
        begin
            debounced_next = raw;
        end
        else
        begin
            due          = pending_reg || (count_reg == pbd_pkg::count_t'(1));
            pending_next = 1'b0;
            if (count_reg != '0)
                count_next = count_reg - pbd_pkg::count_t'(1);

            if (pin_edge)
            begin
                // restart the window; any sample due now is dropped
                count_next               = count_load;
                stable_next              = 1'b0;
                result_next.scan_disable = raw;
                due                      = 1'b0;
            end
            else if (sim_change)
            begin
                count_next   = '0;
                pending_next = 1'b1;
                stable_next  = 1'b0;
                due          = 1'b0;
            end

            if (due)
            begin
                result_next.scan_enable = !raw;
                if (raw != debounced_reg)
                begin
                    debounced_next           = raw;
                    result_next.change_event = 1'b1;
                    result_next.press_event  = raw;
                end
                stable_next = 1'b1;
            end
        end

        result_next.pressed = debounced_next;
        result_next.stable  = stable_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounced_reg  <= 1'b0;
            stable_reg     <= 1'b1;
            count_reg      <= '0;
            pending_reg    <= 1'b0;
            prev_level_reg <= 1'b0;
            prev_sim_reg   <= 1'b0;
            init_done_reg  <= 1'b0;
        end
        else if (accept)
        begin
            debounced_reg  <= debounced_next;
            stable_reg     <= stable_next;
            count_reg      <= count_next;
            pending_reg    <= pending_next;
            prev_level_reg <= button_level;
            prev_sim_reg   <= simulate_press;
            init_done_reg  <= 1'b1;
        end
    end

    // Output register: hold while stalled, refill on every accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (accept)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign pressed      = result_reg.pressed;
    assign stable       = result_reg.stable;
    assign scan_disable = result_reg.scan_disable;
    assign scan_enable  = result_reg.scan_enable;
    assign change_event = result_reg.change_event;
    assign press_event  = result_reg.press_event;

endmodule

[src/pbd_checker.sv]
// Port-level checker for the power button debouncer, bound to the top level.
`include "assert_macros.svh"

module pbd_checker (
    input logic clk,
    input logic rst_n,
    input logic tick_stall,
    input logic result_valid,
    input logic result_stall,
    input logic pressed,
    input logic stable,
    input logic scan_disable,
    input logic scan_enable,
    input logic change_event,
    input logic press_event
);

    // a press event is a change into the pressed state
    `ASSERT_IMPL(a_press_is_change, clk, rst_n, result_valid && press_event,
                 change_event && pressed)
    // a state change comes only from a sample, which settles the window
    `ASSERT_IMPL(a_change_sets_stable, clk, rst_n, result_valid && change_event, stable)
    // an edge tick never samples
    `ASSERT_IMPL(a_scan_exclusive, clk, rst_n, result_valid, !(scan_disable && scan_enable))
    // stall the tick side only while a result is held back
    `ASSERT_IMPL(a_stall_only_when_full, clk, rst_n, tick_stall, result_valid && result_stall)
    // a stalled result holds
    `ASSERT_NEXT(a_result_holds, clk, rst_n, result_valid && result_stall,
                 result_valid && $stable(pressed) && $stable(change_event))

endmodule

bind power_button_debouncer pbd_checker u_pbd_checker (.*);

[tb/tb_power_button_debouncer.sv]
// Self-checking testbench for the power button debouncer: directed corner cases and random presses.
module tb_power_button_debouncer;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES = 6;
    localparam int PHASE_TICKS = 110;
    // Index 3 decodes to no register
    localparam logic [pbd_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_we;
    logic [pbd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [pbd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data;
    logic                                tick_valid;
    logic                                tick_stall;
    logic                                button_level;
    logic                                lid_open;
    logic                                simulate_press;
    logic                                result_valid;
    logic                                result_stall;
    logic                                pressed;
    logic                                stable;
    logic                                scan_disable;
    logic                                scan_enable;
    logic                                change_event;
    logic                                press_event;

    // Debouncer copy: configuration and state
    logic [pbd_pkg::DELAY_WIDTH-1:0] delay_ticks;
    logic                            press_level;
    logic                            lid_ignored;
    logic                            held_state;
    logic                            settled;
    pbd_pkg::count_t                 countdown;
    logic                            sample_next;
    logic                            last_pin;
    logic                            last_sim;
    logic                            primed;

    pbd_pkg::result_t tick_outcomes[$];

    bit tx_idle;
    bit rx_idle;
    logic pin;
    logic lid;
    logic sim;
    int errors;
    int cycles;
    int ticks_sent;
    int outcomes_seen;
    int reg_writes;
    int press_count;
    int release_samples;
    int disable_count;

    power_button_debouncer i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .tick_valid     (tick_valid),
        .tick_stall     (tick_stall),
        .button_level   (button_level),
        .lid_open       (lid_open),
        .simulate_press (simulate_press),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .pressed        (pressed),
        .stable         (stable),
        .scan_disable   (scan_disable),
        .scan_enable    (scan_enable),
        .change_event   (change_event),
        .press_event    (press_event)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic pbd_pkg::result_t debounce_tick(input logic lvl, input logic lid_in,
                                                       input logic sim_in);
        pbd_pkg::result_t r;
        logic             raw;
        logic             due;
        r = '0;
        due = 1'b0;
        if (sim_in)
            raw = 1'b1;
        else if (!lid_ignored && !lid_in)
            raw = 1'b0;
        else
            raw = (lvl == press_level);
        if (!primed)
        begin
            held_state = raw;
            primed = 1'b1;
        end
        else
        begin
            due = sample_next;
            sample_next = 1'b0;
            if (countdown != '0)
            begin
                countdown = countdown - 1'b1;
                if (countdown == '0)
                    due = 1'b1;
            end
            // A pin edge wins over an expiry and over a simulate change
            if (lvl != last_pin)
            begin
                countdown = (delay_ticks == '0) ? pbd_pkg::count_t'(1)
                                                : pbd_pkg::count_t'(delay_ticks);
                settled = 1'b0;
                r.scan_disable = raw;
                due = 1'b0;
            end
            else if (sim_in != last_sim)
            begin
                countdown = '0;
                sample_next = 1'b1;
                settled = 1'b0;
                due = 1'b0;
            end
            if (due)
            begin
                r.scan_enable = !raw;
                if (raw != held_state)
                begin
                    held_state = raw;
                    r.change_event = 1'b1;
                    r.press_event = raw;
                end
                settled = 1'b1;
            end
        end
        last_pin = lvl;
        last_sim = sim_in;
        r.pressed = held_state;
        r.stable = settled;
        return r;
    endfunction

    task automatic report(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    // Compare each accepted result item with the oldest expectation
    always @(posedge clk)
    begin
        pbd_pkg::result_t got;
        pbd_pkg::result_t want;
        string            names [6];
        names = '{"pressed", "stable", "scan_disable", "scan_enable",
                  "change_event", "press_event"};
        if (rst_n && result_valid && !result_stall)
        begin
            got = '{pressed, stable, scan_disable, scan_enable, change_event, press_event};
            if (tick_outcomes.size() == 0)
                report("result item with none expected");
            else
            begin
                want = tick_outcomes.pop_front();
                for (int b = 0; b < 6; b++)
                    if (got[5-b] !== want[5-b])
                        report($sformatf("item %0d %s got %b want %b",
                                         outcomes_seen, names[b], got[5-b], want[5-b]));
                press_count += want.press_event;
                release_samples += want.scan_enable;
                disable_count += want.scan_disable;
            end
            outcomes_seen++;
        end
    end

    // Result side: while idling is on, stall for a random number of cycles before each item
    initial
    begin
        int n;
        result_stall = 1'b0;
        forever
        begin
            n = rx_idle ? $urandom_range(0, 10) : 0;
            if (n > 0)
            begin
                @(negedge clk) result_stall <= 1'b1;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk) result_stall <= 1'b0;
            do @(posedge clk); while (!(rst_n && result_valid));
        end
    end

    task automatic send_tick(input logic lvl, input logic lid_in, input logic sim_in);
        int gap;
        gap = tx_idle ? $urandom_range(0, 10) : 0;
        repeat (gap) @(negedge clk) tick_valid <= 1'b0;
        @(negedge clk);
        tick_valid <= 1'b1;
        button_level <= lvl;
        lid_open <= lid_in;
        simulate_press <= sim_in;
        do @(posedge clk); while (tick_stall);
        tick_outcomes.push_back(debounce_tick(lvl, lid_in, sim_in));
        ticks_sent++;
    endtask

    task automatic hold(input logic lvl, input logic lid_in, input logic sim_in, input int n);
        repeat (n) send_tick(lvl, lid_in, sim_in);
    endtask

    // Drop valid and wait until every expected result item has come
    task automatic settle();
        @(negedge clk) tick_valid <= 1'b0;
        while (tick_outcomes.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [pbd_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [pbd_pkg::CFG_DATA_WIDTH-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk) cfg_we <= 1'b0;
        case (idx)
            pbd_pkg::REG_DEBOUNCE_TICKS: delay_ticks = data;
            pbd_pkg::REG_ACTIVE_LEVEL:   press_level = data[0];
            pbd_pkg::REG_IGNORE_LID:     lid_ignored = data[0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_idling(input bit on);
        tx_idle = on;
        rx_idle = on;
    endtask

    // Reset defaults: active low, lid gates the press, long default delay
    task automatic test_reset_defaults();
        set_idling(1'b0);
        hold(1'b1, 1'b1, 1'b0, 1);
        // edge with the lid closed: raw reads released, no scan disable
        hold(1'b0, 1'b0, 1'b0, 1);
        hold(1'b0, 1'b1, 1'b0, 20);
        settle();
    endtask

    task automatic test_register_extremes();
        write_reg(pbd_pkg::REG_DEBOUNCE_TICKS, '0);
        write_reg(pbd_pkg::REG_ACTIVE_LEVEL, '1);
        write_reg(pbd_pkg::REG_IGNORE_LID, 16'hFFFE);
        write_reg(REG_UNUSED, '1);
        set_idling(1'b1);
        // zero delay behaves as one tick
        hold(1'b1, 1'b1, 1'b0, 3);
        hold(1'b0, 1'b1, 1'b0, 3);
        settle();
        write_reg(pbd_pkg::REG_DEBOUNCE_TICKS, '1);
        set_idling(1'b0);
        hold(1'b1, 1'b1, 1'b0, 20);
        settle();
    endtask

    task automatic test_debounce_corners();
        write_reg(pbd_pkg::REG_DEBOUNCE_TICKS, 16'd2);
        set_idling(1'b1);
        hold(1'b0, 1'b1, 1'b0, 2);
        hold(1'b1, 1'b1, 1'b0, 2);
        // edge lands on the expiry tick: restart the count
        hold(1'b0, 1'b1, 1'b0, 3);
        hold(1'b1, 1'b1, 1'b0, 3);
        // simulate change alone: sample on the following tick
        hold(1'b1, 1'b1, 1'b1, 2);
        // pin edge together with a simulate change
        hold(1'b0, 1'b1, 1'b0, 3);
        // lid closed masks an active pin
        hold(1'b1, 1'b0, 1'b0, 3);
        hold(1'b0, 1'b0, 1'b1, 2);
        hold(1'b0, 1'b0, 1'b0, 2);
        settle();
        write_reg(pbd_pkg::REG_IGNORE_LID, 16'h0001);
        write_reg(pbd_pkg::REG_ACTIVE_LEVEL, 16'hFFFE);
        hold(1'b1, 1'b0, 1'b0, 3);
        hold(1'b0, 1'b0, 1'b0, 3);
        settle();
    endtask

    task automatic random_gesture();
        int kind;
        int n;
        int span;
        kind = $urandom_range(0, 9);
        span = (delay_ticks == '0) ? 1 : int'(delay_ticks);
        if (kind < 6)
        begin
            // bounce, then hold the new level past the debounce window
            if ($urandom_range(0, 6) == 0)
                lid = ~lid;
            n = $urandom_range(0, 3);
            repeat (2 * n)
            begin
                pin = ~pin;
                send_tick(pin, lid, sim);
            end
            pin = ~pin;
            hold(pin, lid, sim, 1 + span + $urandom_range(0, 2));
        end
        else if (kind < 8)
        begin
            sim = ~sim;
            hold(pin, lid, sim, 1 + $urandom_range(0, 2));
        end
        else
        begin
            repeat ($urandom_range(1, 4))
            begin
                {pin, lid, sim} = 3'($urandom);
                send_tick(pin, lid, sim);
            end
        end
    endtask

    task automatic test_random_presses();
        int stop;
        int sel;
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            sel = $urandom_range(0, 9);
            if (sel == 0)
                write_reg(pbd_pkg::REG_DEBOUNCE_TICKS, '0);
            else if (sel == 1)
                write_reg(pbd_pkg::REG_DEBOUNCE_TICKS,
                          pbd_pkg::CFG_DATA_WIDTH'($urandom_range(10, 40)));
            else
                write_reg(pbd_pkg::REG_DEBOUNCE_TICKS,
                          pbd_pkg::CFG_DATA_WIDTH'($urandom_range(1, 6)));
            write_reg(pbd_pkg::REG_ACTIVE_LEVEL, pbd_pkg::CFG_DATA_WIDTH'($urandom));
            write_reg(pbd_pkg::REG_IGNORE_LID, pbd_pkg::CFG_DATA_WIDTH'($urandom));
            set_idling(p != 2);
            stop = ticks_sent + PHASE_TICKS;
            while (ticks_sent < stop)
            begin
                random_gesture();
                // pause the sender until the result side is empty
                if (p == 1 && ticks_sent >= stop - PHASE_TICKS / 2 && tick_outcomes.size() != 0)
                    settle();
            end
        end
        settle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        tick_valid = 1'b0;
        button_level = 1'b0;
        lid_open = 1'b0;
        simulate_press = 1'b0;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        errors = 0;
        cycles = 0;
        ticks_sent = 0;
        outcomes_seen = 0;
        reg_writes = 0;
        press_count = 0;
        release_samples = 0;
        disable_count = 0;
        pin = 1'b0;
        lid = 1'b1;
        sim = 1'b0;
        delay_ticks = pbd_pkg::DEBOUNCE_RESET;
        press_level = 1'b0;
        lid_ignored = 1'b0;
        held_state = 1'b0;
        settled = 1'b1;
        countdown = '0;
        sample_next = 1'b0;
        last_pin = 1'b0;
        last_sim = 1'b0;
        primed = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_debounce_corners();
        test_random_presses();

        repeat (5) @(posedge clk);
        $display("run covered %0d ticks and %0d result items over %0d register writes",
                 ticks_sent, outcomes_seen, reg_writes);
        $display("debounced presses %0d, released samples %0d, scan disables %0d",
                 press_count, release_samples, disable_count);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
